@@ hdl/tsar_pkg.sv @@
// Shared types and constants of the TS audio slice reassembler.
package tsar_pkg;

  localparam int unsigned MAX_LANES = 7;
  localparam int unsigned LANE_W    = 56;
  localparam int unsigned SEQ_W     = 16;
  localparam int unsigned CNT_W     = 3;
  localparam int unsigned PID_W     = 13;
  localparam int unsigned LEN_W     = 16;
  localparam int unsigned ADD_W     = 8;
  localparam int unsigned PKT_W     = 11;
  localparam int unsigned TOTAL_W   = 20;
  localparam int unsigned ACT_W     = 3;

  localparam logic [PID_W-1:0]   PID_RESET     = 13'h1100;
  localparam logic [LEN_W-1:0]   PES_HDR_BYTES = 16'd14;
  localparam logic [ADD_W-1:0]   TS_PAYLOAD    = 8'd184;
  localparam logic [ADD_W-1:0]   PUSI_BYTES    = 8'd164;  // payload minus 20 header bytes
  localparam logic [ADD_W-1:0]   ADAPT_BASE    = 8'd183;  // payload minus the length byte
  localparam logic [1:0]         AFC_PAYLOAD   = 2'b01;
  localparam logic [1:0]         AFC_BOTH      = 2'b11;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX     = 20'hFFFFF;

  // Result action codes
  localparam logic [ACT_W-1:0] ACT_IGNORED  = 3'd0;
  localparam logic [ACT_W-1:0] ACT_APPENDED = 3'd1;
  localparam logic [ACT_W-1:0] ACT_COMPLETE = 3'd2;
  localparam logic [ACT_W-1:0] ACT_GAP      = 3'd3;
  localparam logic [ACT_W-1:0] ACT_OVERRUN  = 3'd4;

  // What one lane finds in its TS packet
  typedef struct packed {
    logic             start;    // unit start on the audio PID
    logic [LEN_W-1:0] pes_len;
    logic             bad;      // matching lane with an unexpected adaptation code
    logic [ADD_W-1:0] add;      // payload bytes this lane contributes
  } lane_res_t;

  // Merged per-word summary, registered ahead of the slice state
  typedef struct packed {
    logic [SEQ_W-1:0] seq;
    logic             any_start;
    logic [LEN_W-1:0] start_len;
    logic             bad;
    logic [PKT_W-1:0] pkt;
  } merge_res_t;

endpackage

@@ hdl/tsar_in_if.sv @@
// Input channel: one RTP datagram word with up to seven TS packet lanes.
interface tsar_in_if;
  import tsar_pkg::*;

  logic              valid;
  logic              ready;
  logic [SEQ_W-1:0]  rtp_seq;
  logic [CNT_W-1:0]  ts_count;
  logic [LANE_W-1:0] ts_lane_0;
  logic [LANE_W-1:0] ts_lane_1;
  logic [LANE_W-1:0] ts_lane_2;
  logic [LANE_W-1:0] ts_lane_3;
  logic [LANE_W-1:0] ts_lane_4;
  logic [LANE_W-1:0] ts_lane_5;
  logic [LANE_W-1:0] ts_lane_6;

  modport source (
    output valid, rtp_seq, ts_count,
    output ts_lane_0, ts_lane_1, ts_lane_2, ts_lane_3, ts_lane_4, ts_lane_5, ts_lane_6,
    input  ready
  );

  modport sink (
    input  valid, rtp_seq, ts_count,
    input  ts_lane_0, ts_lane_1, ts_lane_2, ts_lane_3, ts_lane_4, ts_lane_5, ts_lane_6,
    output ready
  );
endinterface

@@ hdl/tsar_out_if.sv @@
// Output channel: one reassembly result word per datagram.
interface tsar_out_if;
  import tsar_pkg::*;

  logic               valid;
  logic               ready;
  logic [ACT_W-1:0]   action;
  logic [PKT_W-1:0]   packet_bytes;
  logic [TOTAL_W-1:0] slice_bytes;
  logic [LEN_W-1:0]   slice_target;
  logic               target_unlimited;
  logic               malformed;

  modport source (
    output valid, action, packet_bytes, slice_bytes, slice_target,
    output target_unlimited, malformed,
    input  ready
  );

  modport sink (
    input  valid, action, packet_bytes, slice_bytes, slice_target,
    input  target_unlimited, malformed,
    output ready
  );
endinterface

@@ hdl/ts_audio_slice_reassembler_unit.sv @@
// Top level of the TS audio slice reassembler.
//
// Reassembles one audio PES slice from RTP datagrams carrying MPEG-2 TS
// packets. Each input word is one datagram (sequence number, lane count and
// up to seven 56-bit lane headers); each produces exactly one result word.
// While searching, the first unit-start lane on audio_pid opens a slice with
// a target of PES length minus 14 (no target below 14). While collecting,
// matching lanes add 164, 184 or 183 minus the adaptation length; a sequence
// gap drops the slice, reaching the target completes it, passing it reports
// an overrun. Throughput is one word per clock unless out_o.ready stalls. A
// word is registered after the lane decoders and merge adder tree, then in the
// slice state and result word. Each lane has its own decoder, so lane count
// sets area, not rate. The user writes the audio_pid register (cfg_we_i /
// cfg_wdata_i) only while the block is idle; the block does not enforce it.
module ts_audio_slice_reassembler_unit
  import tsar_pkg::*;
#(
  parameter int unsigned LANES = 7
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [PID_W-1:0] cfg_wdata_i,
  tsar_in_if.sink          in_i,
  tsar_out_if.source       out_o
);

  logic [PID_W-1:0]  audio_pid_q;
  logic [LANE_W-1:0] lane_w [MAX_LANES];
  lane_res_t         lane_res [LANES];
  merge_res_t        merge_res;

  logic s1_valid_q, s1_valid_d;
  logic out_valid_q, out_valid_d;
  logic s2_free;
  logic s1_adv;
  logic in_take;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      audio_pid_q <= PID_RESET;
    end else if (cfg_we_i) begin
      audio_pid_q <= cfg_wdata_i;
    end
  end

  assign lane_w[0] = in_i.ts_lane_0;
  assign lane_w[1] = in_i.ts_lane_1;
  assign lane_w[2] = in_i.ts_lane_2;
  assign lane_w[3] = in_i.ts_lane_3;
  assign lane_w[4] = in_i.ts_lane_4;
  assign lane_w[5] = in_i.ts_lane_5;
  assign lane_w[6] = in_i.ts_lane_6;

  // Lane decoders; a lane at or above ts_count contributes nothing
  for (genvar g = 0; g < LANES; g++) begin : g_lane
    tsar_lane u_lane (
      .lane_i (lane_w[g]),
      .en_i   (in_i.ts_count > CNT_W'(g)),
      .pid_i  (audio_pid_q),
      .res_o  (lane_res[g])
    );
  end

  // Pipeline control: advance stage one when the result register frees up
  assign s2_free    = !out_valid_q || out_o.ready;
  assign s1_adv     = s1_valid_q && s2_free;
  assign in_i.ready = !s1_valid_q || s2_free;
  assign in_take    = in_i.valid && in_i.ready;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_take) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s1_adv) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  tsar_merge #(
    .LANES (LANES)
  ) u_merge (
    .clk_i   (clk_i),
    .load_i  (in_take),
    .seq_i   (in_i.rtp_seq),
    .lanes_i (lane_res),
    .res_o   (merge_res)
  );

  tsar_ctrl u_ctrl (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .take_i             (s1_adv),
    .m_i                (merge_res),
    .action_o           (out_o.action),
    .packet_bytes_o     (out_o.packet_bytes),
    .slice_bytes_o      (out_o.slice_bytes),
    .slice_target_o     (out_o.slice_target),
    .target_unlimited_o (out_o.target_unlimited),
    .malformed_o        (out_o.malformed)
  );

  assign out_o.valid = out_valid_q;

endmodule

@@ hdl/tsar_lane.sv @@
// Per-lane TS header decode: PID match, unit start and payload byte count.
module tsar_lane
  import tsar_pkg::*;
(
  input  logic [LANE_W-1:0] lane_i,
  input  logic              en_i,
  input  logic [PID_W-1:0]  pid_i,
  output lane_res_t         res_o
);

  logic             pusi;
  logic [PID_W-1:0] pid;
  logic [1:0]       afc;
  logic [ADD_W-1:0] first;
  logic             match;

  assign pusi  = lane_i[22];
  assign pid   = lane_i[20:8];
  assign afc   = lane_i[5:4];
  assign first = lane_i[39:32];
  assign match = en_i && (pid == pid_i);

  always_comb begin
    res_o.start   = match && pusi;
    res_o.pes_len = lane_i[55:40];
    res_o.bad     = 1'b0;
    res_o.add     = '0;
    if (match) begin
      if (afc != AFC_PAYLOAD && afc != AFC_BOTH) begin
        res_o.bad = 1'b1;
      end else if (pusi) begin
        res_o.add = PUSI_BYTES;
      end else if (afc == AFC_PAYLOAD) begin
        res_o.add = TS_PAYLOAD;
      end else if (first <= ADAPT_BASE) begin
        res_o.add = ADAPT_BASE - first;
      end
    end
  end

endmodule

@@ hdl/tsar_merge.sv @@
// Lane merge: sum of lane bytes, first unit start, malformed flag; registered.
module tsar_merge
  import tsar_pkg::*;
#(
  parameter int unsigned LANES = 7
) (
  input  logic             clk_i,
  input  logic             load_i,
  input  logic [SEQ_W-1:0] seq_i,
  input  lane_res_t        lanes_i [LANES],
  output merge_res_t       res_o
);

  merge_res_t res_d;
  merge_res_t res_q;

  always_comb begin
    res_d.seq       = seq_i;
    res_d.any_start = 1'b0;
    res_d.start_len = '0;
    res_d.bad       = 1'b0;
    res_d.pkt       = '0;
    // Walk downward so the lowest starting lane wins
    for (int i = LANES - 1; i >= 0; i--) begin
      if (lanes_i[i].start) begin
        res_d.any_start = 1'b1;
        res_d.start_len = lanes_i[i].pes_len;
      end
    end
    for (int i = 0; i < LANES; i++) begin
      res_d.bad = res_d.bad | lanes_i[i].bad;
      res_d.pkt = res_d.pkt + PKT_W'(lanes_i[i].add);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

@@ hdl/tsar_ctrl.sv @@
// Slice state: start capture, sequence check, running count and result register.
module tsar_ctrl
  import tsar_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               take_i,
  input  merge_res_t         m_i,
  output logic [ACT_W-1:0]   action_o,
  output logic [PKT_W-1:0]   packet_bytes_o,
  output logic [TOTAL_W-1:0] slice_bytes_o,
  output logic [LEN_W-1:0]   slice_target_o,
  output logic               target_unlimited_o,
  output logic               malformed_o
);

  logic               collecting_q, collecting_d;
  logic [SEQ_W-1:0]   prev_seq_q, prev_seq_d;
  logic [TOTAL_W-1:0] byte_total_q, byte_total_d;
  logic [LEN_W-1:0]   target_q, target_d;
  logic               no_target_q, no_target_d;
  logic [TOTAL_W:0]   sum;

  logic [ACT_W-1:0]   action_q, action_d;
  logic [PKT_W-1:0]   pkt_q, pkt_d;
  logic               bad_q, bad_d;

  always_comb begin
    collecting_d = collecting_q;
    prev_seq_d   = prev_seq_q;
    byte_total_d = byte_total_q;
    target_d     = target_q;
    no_target_d  = no_target_q;
    action_d     = ACT_IGNORED;
    pkt_d        = '0;
    bad_d        = 1'b0;
    sum          = '0;

    // Open a slice; back the expected sequence up so this word counts
    if (!collecting_q && m_i.any_start) begin
      no_target_d  = m_i.start_len < PES_HDR_BYTES;
      target_d     = no_target_d ? '0 : m_i.start_len - PES_HDR_BYTES;
      collecting_d = 1'b1;
      byte_total_d = '0;
      prev_seq_d   = m_i.seq - SEQ_W'(1);
    end

    if (collecting_d) begin
      if (m_i.seq != prev_seq_d + SEQ_W'(1)) begin
        action_d     = ACT_GAP;
        collecting_d = 1'b0;
        byte_total_d = '0;
      end else begin
        prev_seq_d   = m_i.seq;
        pkt_d        = m_i.pkt;
        bad_d        = m_i.bad;
        sum          = {1'b0, byte_total_d} + (TOTAL_W + 1)'(m_i.pkt);
        byte_total_d = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
        action_d     = ACT_APPENDED;
        if (!no_target_d) begin
          if (byte_total_d == TOTAL_W'(target_d)) begin
            action_d     = ACT_COMPLETE;
            collecting_d = 1'b0;
          end else if (byte_total_d > TOTAL_W'(target_d)) begin
            action_d     = ACT_OVERRUN;
            collecting_d = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      collecting_q <= 1'b0;
      prev_seq_q   <= '0;
      byte_total_q <= '0;
      target_q     <= '0;
      no_target_q  <= 1'b0;
    end else if (take_i) begin
      collecting_q <= collecting_d;
      prev_seq_q   <= prev_seq_d;
      byte_total_q <= byte_total_d;
      target_q     <= target_d;
      no_target_q  <= no_target_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i) begin
      action_q <= action_d;
      pkt_q    <= pkt_d;
      bad_q    <= bad_d;
    end
  end

  assign action_o           = action_q;
  assign packet_bytes_o     = pkt_q;
  assign malformed_o        = bad_q;
  // Slice state registers only move on take, so they track the result word
  assign slice_bytes_o      = byte_total_q;
  assign slice_target_o     = target_q;
  assign target_unlimited_o = no_target_q;

endmodule
